// ----- src/cnbc_pkg.sv -----
// Shared types, constants and helpers for the cross-neighbourhood binary coder.
// Used by the result queue and the top module of the block; depends on nothing else.
`default_nettype none

package cnbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int CODE_W  = 5;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int EXT_A = (CFG_W > WID_W) ? CFG_W : WID_W;
  localparam int EXT_W = ((EXT_A > HGT_W) ? EXT_A : HGT_W) + 1;

  localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(1024);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Code bits.
  localparam logic [CODE_W-1:0] BIT_CENTRE = 5'h01;
  localparam logic [CODE_W-1:0] BIT_RIGHT  = 5'h02;
  localparam logic [CODE_W-1:0] BIT_LEFT   = 5'h04;
  localparam logic [CODE_W-1:0] BIT_BELOW  = 5'h08;
  localparam logic [CODE_W-1:0] BIT_ABOVE  = 5'h10;

  // Line buffer word: one flag of the upper row and one of the middle row.
  localparam int ENT_W   = 2;
  localparam int ENT_UP  = 1;
  localparam int ENT_MID = 0;

  // Result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Up to two results caused by one pixel: the code of the pixel above and,
  // on the last row, the pixel's own zero code.
  typedef struct packed {
    logic              has_first;
    logic              has_second;
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              eoi;
  } res_t;

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] cfg);
    logic [EXT_W-1:0] v;
    v = EXT_W'(cfg);
    if (v == '0) return WID_W'(1);
    if (v > EXT_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
    return WID_W'(v);
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] cfg);
    logic [EXT_W-1:0] v;
    v = EXT_W'(cfg);
    if (v == '0) return HGT_W'(1);
    if (v > EXT_W'(MAX_HEIGHT)) return HGT_W'(MAX_HEIGHT);
    return HGT_W'(v);
  endfunction

endpackage

`default_nettype wire

// ----- src/cnbc_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module cnbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ----- src/cnbc_res_queue.sv -----
// Result queue: holds the results of up to Q_DEPTH pixels and hands them out
// one request at a time. Depends on cnbc_pkg.
`default_nettype none

module cnbc_res_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire cnbc_pkg::res_t               push_data,
  output logic      [cnbc_pkg::Q_CNT_W-1:0] count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [cnbc_pkg::CODE_W-1:0]  out_code,
  output logic      [cnbc_pkg::POS_W-1:0]   out_row,
  output logic      [cnbc_pkg::POS_W-1:0]   out_col,
  output logic                              out_last_of_run,
  output logic                              out_end_of_image
);
  import cnbc_pkg::*;

  res_t             q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic             sub_r, sub_nxt;
  res_t             head;
  logic             cur_first;
  logic             out_fire;
  logic             pop;

  assign head      = q_mem[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign count     = count_r;

  // The first result of an entry is the code of the pixel one row up.
  assign cur_first        = head.has_first && !sub_r;
  assign out_code         = cur_first ? head.code : '0;
  assign out_row          = cur_first ? POS_W'(head.row - ROW_W'(1)) : POS_W'(head.row);
  assign out_col          = POS_W'(head.col);
  assign out_last_of_run  = cur_first ? !head.has_second : 1'b1;
  assign out_end_of_image = cur_first ? 1'b0 : head.eoi;

  assign out_fire = out_valid && !out_stall;
  assign pop      = out_fire && out_last_of_run;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    unique if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
    sub_nxt = sub_r;
    if (out_fire) begin
      sub_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (count_r == Q_CNT_W'(Q_DEPTH))))
    else $error("result queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count out of range");

  a_sub_second: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (out_valid && head.has_first && head.has_second))
    else $error("second result pending on an entry that has none");

endmodule

`default_nettype wire

// ----- src/cross_neighbourhood_binary_code_unit.sv -----
// Cross-neighbourhood binary coder: nonzero pattern of each pixel and its 4 neighbours.
// Depends on cnbc_pkg, cnbc_ram and cnbc_res_queue.
//
// Usage: grayscale pixels enter in raster order on in_pixel (valid/stall).
// Each accepted pixel of row r yields the 5-bit code of the pixel at the same
// column of row r-1; pixels of the last row also yield their own zero code,
// so a last-row pixel causes two requests on the output. out_last_of_run marks
// the final request caused by a pixel, out_end_of_image the image's last pixel.
// Border pixels always code 0. The image size is set through the cfg_ port
// (index 0 width, index 1 height) while the block is idle.
// A result passes through the stage register s1_r and then the result queue.
// Throughput: one pixel per cycle while in_stall is low, set by the single
// line-buffer RAM that is read at the pixel's column and the next one and
// written back in the next cycle; on the last row the input stalls.
// A four-entry result queue decouples the sides: when the receiver stalls the
// queue fills and in_stall rises; results are never dropped.
// Reset (synchronous, rst_n low) clears position and queue and sets both
// sizes to 1024; the line buffer needs no clearing pass.
`default_nettype none

module cross_neighbourhood_binary_code_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cnbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cnbc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cnbc_pkg::PIX_W-1:0]     in_pixel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [cnbc_pkg::CODE_W-1:0]    out_code,
  output logic      [cnbc_pkg::POS_W-1:0]     out_row,
  output logic      [cnbc_pkg::POS_W-1:0]     out_col,
  output logic                                out_last_of_run,
  output logic                                out_end_of_image
);
  import cnbc_pkg::*;

  typedef struct packed {
    logic             f;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic             first;
    logic             inner;
    logic             last_row;
    logic             eoi;
    logic             fwd_a;
    logic             fwd_b;
    logic [ENT_W-1:0] fwd_data;
  } stage_t;

  // Configuration, kept in clamped form.
  logic [WID_W-1:0] w_r, w_nxt;
  logic [HGT_W-1:0] h_r, h_nxt;
  logic [COL_W-1:0] wm1_r, wm1_nxt;
  logic [ROW_W-1:0] hm1_r, hm1_nxt;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  stage_t           s1_r, s1_nxt;
  logic             s1_v_r;
  logic             prev_mid_r, prev_mid_nxt;

  logic             in_fire;
  logic             col_wrap;
  logic [ROW_W:0]   row_inc;
  logic             row_wrap;
  logic [COL_W-1:0] c_a;
  logic [ROW_W-1:0] r_a;
  logic             last_col;
  logic             last_row;
  logic [COL_W-1:0] addr_b;

  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] rd_a, rd_b;
  logic [ENT_W-1:0] ent_c, ent_n;
  logic [CODE_W-1:0] code_b;
  res_t             push_data;
  logic             push;
  logic [Q_CNT_W-1:0] q_count;

  // ---------------- configuration ----------------
  always_comb begin
    w_nxt   = w_r;
    h_nxt   = h_r;
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          w_nxt   = clamp_width(cfg_wdata);
          wm1_nxt = COL_W'(clamp_width(cfg_wdata) - WID_W'(1));
        end
        REG_HEIGHT: begin
          h_nxt   = clamp_height(cfg_wdata);
          hm1_nxt = ROW_W'(clamp_height(cfg_wdata) - HGT_W'(1));
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
    end
  end

  // ---------------- stage A: position and RAM read ----------------
  assign in_stall = ({1'b0, q_count} + (Q_CNT_W + 1)'(s1_v_r)) >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign in_fire  = in_valid && !in_stall;

  // A size change can leave the position outside the new image.
  assign col_wrap = WID_W'(col_r) >= w_r;
  assign c_a      = col_wrap ? '0 : col_r;
  assign row_inc  = {1'b0, row_r} + (ROW_W + 1)'(col_wrap);
  assign row_wrap = row_inc >= (ROW_W + 1)'(h_r);
  assign r_a      = row_wrap ? '0 : row_inc[ROW_W-1:0];
  assign last_col = (c_a == wm1_r);
  assign last_row = (r_a == hm1_r);
  assign addr_b   = c_a + COL_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r_a + ROW_W'(1);
      end else begin
        col_nxt = c_a + COL_W'(1);
        row_nxt = r_a;
      end
    end
  end

  // The RAM returns old data when the same entry is written in the read
  // cycle, so the pending write is captured alongside the request.
  always_comb begin
    s1_nxt.f        = (in_pixel != '0);
    s1_nxt.r        = r_a;
    s1_nxt.c        = c_a;
    s1_nxt.first    = (r_a != '0);
    s1_nxt.inner    = (r_a >= ROW_W'(2)) && (c_a != '0) && !last_col;
    s1_nxt.last_row = last_row;
    s1_nxt.eoi      = last_col;
    s1_nxt.fwd_a    = ram_we && (ram_waddr == c_a);
    s1_nxt.fwd_b    = ram_we && (ram_waddr == addr_b);
    s1_nxt.fwd_data = ram_wdata;
  end

  // ---------------- stage B: code and write-back ----------------
  assign ent_c = s1_r.fwd_a ? s1_r.fwd_data : rd_a;
  assign ent_n = s1_r.fwd_b ? s1_r.fwd_data : rd_b;

  // The left neighbour's upper flag was moved there from the middle row by
  // the previous pixel, so it equals the middle flag that pixel read.
  always_comb begin
    code_b = '0;
    if (s1_r.inner) begin
      if (ent_c[ENT_MID]) code_b = code_b | BIT_CENTRE;
      if (ent_n[ENT_MID]) code_b = code_b | BIT_RIGHT;
      if (prev_mid_r)     code_b = code_b | BIT_LEFT;
      if (s1_r.f)         code_b = code_b | BIT_BELOW;
      if (ent_c[ENT_UP])  code_b = code_b | BIT_ABOVE;
    end
  end

  assign ram_we    = s1_v_r;
  assign ram_waddr = s1_r.c;
  assign ram_wdata = {ent_c[ENT_MID], s1_r.f};

  assign prev_mid_nxt = s1_v_r ? ent_c[ENT_MID] : prev_mid_r;

  assign push                 = s1_v_r && (s1_r.first || s1_r.last_row);
  assign push_data.has_first  = s1_r.first;
  assign push_data.has_second = s1_r.last_row;
  assign push_data.code       = code_b;
  assign push_data.row        = s1_r.r;
  assign push_data.col        = s1_r.c;
  assign push_data.eoi        = s1_r.eoi;

  cnbc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_en     (in_fire),
    .rd_addr_a (c_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  cnbc_res_queue u_res_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_data        (push_data),
    .count            (q_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code         (out_code),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_image (out_end_of_image)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    prev_mid_r <= prev_mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= clamp_width(RESET_SIZE);
      h_r    <= clamp_height(RESET_SIZE);
      wm1_r  <= COL_W'(clamp_width(RESET_SIZE) - WID_W'(1));
      hm1_r  <= ROW_W'(clamp_height(RESET_SIZE) - HGT_W'(1));
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      wm1_r  <= wm1_nxt;
      hm1_r  <= hm1_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= in_fire;
    end
  end

  a_stage_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(in_valid && !in_stall))
    else $error("write-back stage active without an accepted pixel");

  a_forward_match: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_r.fwd_a) |-> ($past(ram_we) && ($past(ram_waddr) == s1_r.c)))
    else $error("forwarded line entry does not match the previous write");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r || (q_count != '0)))
    else $error("input stalled with nothing in flight");

endmodule

`default_nettype wire
